// ===== sv/psd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial series divider package
// Codes, command and status types, and saturation shared by the block.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam logic [1:0] MODE_LOAD_NUM = 2'd0;
  localparam logic [1:0] MODE_LOAD_DEN = 2'd1;
  localparam logic [1:0] MODE_START    = 2'd2;

  localparam logic [1:0] CFG_REPS      = 2'd0;
  localparam logic [1:0] CFG_NUM_TERMS = 2'd1;
  localparam logic [1:0] CFG_DEN_TERMS = 2'd2;

  localparam int DIV_STEPS = 48;
  localparam int REP_LIMIT = 64;

  typedef struct packed {
    logic accept;
    logic idx_zero;
    logic idx_to_ds;
    logic idx_inc;
    logic clr_wr;
    logic lead_take;
    logic div_start;
    logic div_den;
    logic sn_wr;
    logic sd_wr;
    logic step_init;
    logic mul;
    logic sub_wr;
    logic emit_term;
    logic emit_zero;
  } psd_cmd_t;

  typedef struct packed {
    logic start;
    logic clr_end;
    logic den_nz;
    logic end_n;
    logic end_d;
    logic end_len;
    logic div_done;
    logic out_free;
    logic last_term;
  } psd_sts_t;

  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    logic [31:0] r;
    if (v > 49'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -49'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/polynomial_series_divider_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial series divider unit
// Loads coefficients and runs fixed-point polynomial long division.
//
// Channel   Direction  Contents
// s_axis    in         tuser mode, tdata term_index and coefficient
// m_axis    out        tuser status, tdata quotient_term and term_power, tlast
// cfg       in         register index and write data, no read-back
//
// Loads are taken only while idle. A start clears the scratch memories, scans
// the denominator for its lead term, scales each used coefficient through one
// shared divider, then computes and emits each quotient term in turn.
// Reset clears control state and restores the configuration defaults only.
// A stalled result output holds the block.
// ----------------------------------------------------------------------------
module polynomial_series_divider_unit
  import psd_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // term_index, coefficient, zero fill
  input  wire logic [1:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // quotient_term, term_power
  output logic             m_axis_tuser,  // status
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i
);

  psd_cmd_t    cmd;
  psd_sts_t    sts;
  logic [31:0] quotient_term;
  logic [7:0]  term_power;

  psd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psd_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (s_axis_tuser),
    .term_index_i    (s_axis_tdata[3:0]),
    .coefficient_i   (s_axis_tdata[35:4]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .quotient_term_o (quotient_term),
    .term_power_o    (term_power),
    .status_o        (m_axis_tuser),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {term_power, quotient_term};

endmodule
`default_nettype wire

// ===== sv/psd_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point divider
// Computes (a * 2^16) / b truncated toward zero and saturated, one quotient
// bit per cycle by restoring division on the magnitudes.
// ----------------------------------------------------------------------------
module psd_divider
  import psd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic        neg_q, neg_d;
  logic [32:0] rem_sh;
  logic [33:0] trial;
  logic [31:0] a_mag, b_mag;

  always_comb begin
    a_mag  = dividend_i[31] ? 32'(-dividend_i) : dividend_i;
    b_mag  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
    rem_sh = {rem_q[31:0], dvd_q[47]};
    trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = {a_mag, 16'h0000};
      rem_d  = '0;
      dsr_d  = b_mag;
      neg_d  = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      rem_d = trial[33] ? rem_sh : trial[32:0];
      dvd_d = {dvd_q[46:0], ~trial[33]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (!neg_q) begin
      quotient_o = (dvd_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q[31:0];
    end else begin
      quotient_o = (dvd_q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-dvd_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== sv/psd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial series divider datapath
// Coefficient stores, scaled denominator and remainder memories, the
// divider, the multiply-subtract unit and the result register.
// ----------------------------------------------------------------------------
module psd_datapath
  import psd_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire psd_cmd_t    cmd_i,
  output psd_sts_t         sts_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [3:0]  term_index_i,
  input  wire logic [31:0] coefficient_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      quotient_term_o,
  output logic [7:0]       term_power_o,
  output logic             status_o,
  output logic             last_o
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  logic [31:0] num_mem [MAX_TERMS];
  logic [31:0] den_mem [MAX_TERMS];
  logic [31:0] rem_mem [MAX_TERMS];
  logic [31:0] dn_mem  [MAX_TERMS];
  logic [31:0] num_rd_q, den_rd_q, rem_rd_q, dn_rd_q;

  logic [6:0]  reps_q;
  logic [4:0]  num_terms_q, den_terms_q;
  logic [6:0]  reps_cl;
  logic [CW-1:0] n_cl, d_cl, len_cl;

  logic [IW-1:0] idx_q, ds_q, ns_q;
  logic          ns_found_q;
  logic [31:0]   lead_q;
  logic [31:0]   q_q, rem_h_q, q_v;
  logic signed [63:0] prod_q;
  logic [6:0]    k_q;
  logic [7:0]    power_q;
  logic          nz_q;
  logic [31:0]   diff;
  logic [CW-1:0] idx_p1;

  logic          div_done;
  logic [31:0]   div_q;

  logic          rem_we, dn_we;
  logic [IW-1:0] rem_wa, dn_wa;
  logic [31:0]   rem_wd, dn_wd;
  logic          load_ok;
  logic [IW-1:0] load_addr;

  logic          out_valid_q;
  logic [31:0]   out_q;
  logic [7:0]    out_power_q;
  logic          out_status_q, out_last_q;
  logic          out_free, last_term;

  always_comb begin
    reps_cl = (reps_q == 7'd0) ? 7'd1 :
              (reps_q > 7'(REP_LIMIT)) ? 7'(REP_LIMIT) : reps_q;
    n_cl = (num_terms_q == 5'd0) ? CW'(1) :
           (8'(num_terms_q) > 8'(MAX_TERMS)) ? CW'(MAX_TERMS) : CW'(num_terms_q);
    d_cl = (den_terms_q == 5'd0) ? CW'(1) :
           (8'(den_terms_q) > 8'(MAX_TERMS)) ? CW'(MAX_TERMS) : CW'(den_terms_q);
    len_cl    = (n_cl > d_cl) ? n_cl : d_cl;
    idx_p1    = CW'(idx_q) + CW'(1);
    load_ok   = 8'(term_index_i) < 8'(MAX_TERMS);
    load_addr = IW'(term_index_i);
    q_v       = (idx_q == '0) ? rem_rd_q : q_q;
    diff      = sat32(49'(signed'(rem_h_q)) - 49'(prod_q >>> 16));
    out_free  = !out_valid_q || out_ready_i;
    last_term = !nz_q || ((8'(k_q) + 8'd1) == 8'(reps_cl));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reps_q      <= 7'd8;
      num_terms_q <= 5'd1;
      den_terms_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REPS:      reps_q      <= cfg_data_i;
        CFG_NUM_TERMS: num_terms_q <= cfg_data_i[4:0];
        CFG_DEN_TERMS: den_terms_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  psd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_den ? den_rd_q : num_rd_q),
    .divisor_i  (lead_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    rem_we = 1'b0;
    rem_wa = idx_q;
    rem_wd = '0;
    dn_we  = 1'b0;
    dn_wa  = idx_q;
    dn_wd  = '0;
    if (cmd_i.clr_wr) begin
      rem_we = 1'b1;
      dn_we  = 1'b1;
    end
    if (cmd_i.sn_wr) begin
      rem_wd = div_q;
      if (ns_found_q) begin
        rem_we = 1'b1;
        rem_wa = idx_q - ns_q;
      end else if (div_q != '0) begin
        rem_we = 1'b1;
        rem_wa = '0;
      end
    end
    if (cmd_i.sd_wr) begin
      dn_we = 1'b1;
      dn_wa = idx_q - ds_q;
      dn_wd = div_q;
    end
    if (cmd_i.sub_wr && (idx_q != '0)) begin
      rem_we = 1'b1;
      rem_wa = idx_q - IW'(1);
      rem_wd = diff;
    end
    if (cmd_i.emit_term) begin
      rem_we = 1'b1;
      rem_wa = IW'(len_cl - CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && load_ok && (mode_i == MODE_LOAD_NUM)) begin
      num_mem[load_addr] <= coefficient_i;
    end
    if (cmd_i.accept && load_ok && (mode_i == MODE_LOAD_DEN)) begin
      den_mem[load_addr] <= coefficient_i;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (dn_we) begin
      dn_mem[dn_wa] <= dn_wd;
    end
    num_rd_q <= num_mem[idx_q];
    den_rd_q <= den_mem[idx_q];
    rem_rd_q <= rem_mem[idx_q];
    dn_rd_q  <= dn_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      ns_found_q  <= 1'b0;
      nz_q        <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_zero) begin
        idx_q <= '0;
      end else if (cmd_i.idx_to_ds) begin
        idx_q <= ds_q;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.clr_wr) begin
        ns_found_q <= 1'b0;
      end else if (cmd_i.sn_wr && !ns_found_q && (div_q != '0)) begin
        ns_found_q <= 1'b1;
      end
      if (cmd_i.step_init || cmd_i.emit_term) begin
        nz_q <= 1'b0;
      end else if (cmd_i.sub_wr && (diff != '0)) begin
        nz_q <= 1'b1;
      end
      if (cmd_i.step_init) begin
        k_q <= '0;
      end else if (cmd_i.emit_term) begin
        k_q <= k_q + 7'd1;
      end
      if (cmd_i.emit_term || cmd_i.emit_zero) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      ns_q <= '0;
    end else if (cmd_i.sn_wr && !ns_found_q && (div_q != '0)) begin
      ns_q <= idx_q;
    end
    if (cmd_i.lead_take) begin
      ds_q   <= idx_q;
      lead_q <= den_rd_q;
    end
    if (cmd_i.step_init) begin
      power_q <= 8'(ds_q) - 8'(ns_q);
    end else if (cmd_i.emit_term) begin
      power_q <= power_q - 8'd1;
    end
    if (cmd_i.mul) begin
      if (idx_q == '0) begin
        q_q <= rem_rd_q;
      end
      prod_q  <= signed'(q_v) * signed'(dn_rd_q);
      rem_h_q <= rem_rd_q;
    end
    if (cmd_i.emit_term) begin
      out_q        <= q_q;
      out_power_q  <= power_q;
      out_status_q <= 1'b0;
      out_last_q   <= last_term;
    end else if (cmd_i.emit_zero) begin
      out_q        <= '0;
      out_power_q  <= '0;
      out_status_q <= 1'b1;
      out_last_q   <= 1'b1;
    end
  end

  always_comb begin
    sts_o.start     = (mode_i == MODE_START);
    sts_o.clr_end   = (idx_q == IW'(MAX_TERMS - 1));
    sts_o.den_nz    = (den_rd_q != '0);
    sts_o.end_n     = (idx_p1 >= n_cl);
    sts_o.end_d     = (idx_p1 >= d_cl);
    sts_o.end_len   = (idx_p1 >= len_cl);
    sts_o.div_done  = div_done;
    sts_o.out_free  = out_free;
    sts_o.last_term = last_term;
  end

  assign out_valid_o     = out_valid_q;
  assign quotient_term_o = out_q;
  assign term_power_o    = out_power_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;

`ifndef SYNTH
  a_div_lead_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (lead_q != '0))
    else $error("division started with a zero lead coefficient");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_term || cmd_i.emit_zero) |-> out_free)
    else $error("result register overwritten before it was taken");

  a_zero_den_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> ((out_q == '0) && out_last_q && (out_power_q == '0)))
    else $error("zero denominator result is malformed");
`endif

endmodule
`default_nettype wire

// ===== sv/psd_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Polynomial series divider controller
// Sequences loading, clearing, scaling and the quotient steps.
// ----------------------------------------------------------------------------
module psd_controller
  import psd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire psd_sts_t sts_i,
  output psd_cmd_t      cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLR    = 4'd1;
  localparam logic [3:0] ST_SCAN_A = 4'd2;
  localparam logic [3:0] ST_SCAN_B = 4'd3;
  localparam logic [3:0] ST_NUM_A  = 4'd4;
  localparam logic [3:0] ST_NUM_B  = 4'd5;
  localparam logic [3:0] ST_NUM_C  = 4'd6;
  localparam logic [3:0] ST_DEN_A  = 4'd7;
  localparam logic [3:0] ST_DEN_B  = 4'd8;
  localparam logic [3:0] ST_DEN_C  = 4'd9;
  localparam logic [3:0] ST_STEP_A = 4'd10;
  localparam logic [3:0] ST_STEP_B = 4'd11;
  localparam logic [3:0] ST_STEP_C = 4'd12;
  localparam logic [3:0] ST_EMIT   = 4'd13;
  localparam logic [3:0] ST_ZERO   = 4'd14;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.start) begin
            cmd_o.idx_zero = 1'b1;
            state_d = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_end) begin
          cmd_o.idx_zero = 1'b1;
          state_d = ST_SCAN_A;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SCAN_A: state_d = ST_SCAN_B;
      ST_SCAN_B: begin
        if (sts_i.den_nz) begin
          cmd_o.lead_take = 1'b1;
          cmd_o.idx_zero  = 1'b1;
          state_d = ST_NUM_A;
        end else if (sts_i.end_d) begin
          state_d = ST_ZERO;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_SCAN_A;
        end
      end
      ST_NUM_A: state_d = ST_NUM_B;
      ST_NUM_B: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_NUM_C;
      end
      ST_NUM_C: begin
        if (sts_i.div_done) begin
          cmd_o.sn_wr = 1'b1;
          if (sts_i.end_n) begin
            cmd_o.idx_to_ds = 1'b1;
            state_d = ST_DEN_A;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = ST_NUM_A;
          end
        end
      end
      ST_DEN_A: state_d = ST_DEN_B;
      ST_DEN_B: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_den   = 1'b1;
        state_d = ST_DEN_C;
      end
      ST_DEN_C: begin
        if (sts_i.div_done) begin
          cmd_o.sd_wr = 1'b1;
          if (sts_i.end_d) begin
            cmd_o.step_init = 1'b1;
            cmd_o.idx_zero  = 1'b1;
            state_d = ST_STEP_A;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = ST_DEN_A;
          end
        end
      end
      ST_STEP_A: state_d = ST_STEP_B;
      ST_STEP_B: begin
        cmd_o.mul = 1'b1;
        state_d = ST_STEP_C;
      end
      ST_STEP_C: begin
        cmd_o.sub_wr = 1'b1;
        if (sts_i.end_len) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = ST_STEP_A;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_term = 1'b1;
          cmd_o.idx_zero  = 1'b1;
          state_d = sts_i.last_term ? ST_IDLE : ST_STEP_A;
        end
      end
      ST_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit_zero = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
